### design/srms_pkg.sv
`default_nettype none

package srms_pkg;

  localparam int unsigned MAX_RECORDS = 64;
  localparam int unsigned ADDR_W      = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W       = ADDR_W + 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic signed [31:0] sort_key;
    logic signed [31:0] payload;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_key;
    logic signed [31:0] sorted_payload;
    logic               final_result;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] payload;
  } rec_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PRIME,
    ST_MERGE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

### design/srms_ram.sv
`default_nettype none

module srms_ram
  import srms_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  we_i,
  input  wire addr_t waddr_i,
  input  wire rec_t  wdata_i,
  input  wire addr_t raddr_a_i,
  input  wire addr_t raddr_b_i,
  output rec_t       rdata_a_o,
  output rec_t       rdata_b_o
);

  rec_t mem_q [MAX_RECORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

### design/stable_record_merge_sort.sv
// Stable record merge sort.
// Input channel (in_valid_i / in_ready_o / in_item_i): one record per item,
// a signed key and a payload. An item with last_item set ends the batch; the
// item that fills the store (MAX_RECORDS records) ends it as well.
// Output channel (out_valid_o / out_ready_i / out_item_o): the batch sorted
// ascending by key, equal keys in arrival order, final_result on the last.
// The records sit in two single-write, dual-read RAMs with registered read
// data; each merge pass streams one RAM into the other at one record a cycle.
// A batch of n records is loaded, then sorted in ceil(log2 n) merge passes,
// each begun by a prime step that sets up its first pair of runs; a final
// prime step then starts emitting. in_ready_o is high only while loading.
// A stalled receiver holds the output register and the emit pointer; no item
// is lost. Reset returns the block to loading with an empty batch; RAM
// contents are not cleared and need not be.
`default_nettype none

module stable_record_merge_sort
  import srms_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  state_e    state_q, state_d;
  cnt_t      count_q, count_d;
  cnt_t      width_q, width_d;
  cnt_t      a_q, a_d;
  cnt_t      b_q, b_d;
  cnt_t      mid_q, mid_d;
  cnt_t      hi_q, hi_d;
  cnt_t      k_q, k_d;
  logic      src_sel_q, src_sel_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  rec_t  rd_a0, rd_b0, rd_a1, rd_b1;
  rec_t  rec_a, rec_b, wdata;
  logic  we0, we1;
  addr_t waddr;
  logic  in_acc;
  logic  take_left;
  logic  out_take;
  cnt_t  base;
  logic [CNT_W:0] base_w, base_2w;
  cnt_t  run_mid, run_hi;
  logic [CNT_W:0] width_x2;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rec_a      = src_sel_q ? rd_a1 : rd_a0;
  assign rec_b      = src_sel_q ? rd_b1 : rd_b0;
  assign out_take   = !out_valid_q || out_ready_i;
  assign width_x2   = {width_q, 1'b0};

  assign take_left = (a_q < mid_q) && ((b_q >= hi_q) || (rec_a.key <= rec_b.key));

  assign base    = (state_q == ST_PRIME) ? '0 : hi_q;
  assign base_w  = {1'b0, base} + {1'b0, width_q};
  assign base_2w = {1'b0, base} + width_x2;
  assign run_mid = (base_w  > {1'b0, count_q}) ? count_q : base_w[CNT_W-1:0];
  assign run_hi  = (base_2w > {1'b0, count_q}) ? count_q : base_2w[CNT_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && (in_item_i.last_item ||
                       (count_q + cnt_t'(1) == cnt_t'(MAX_RECORDS)))) begin
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_d = (width_q >= count_q) ? ST_EMIT : ST_MERGE;
      end
      ST_MERGE: begin
        if ((k_q + cnt_t'(1) == hi_q) && (hi_q == count_q)) begin
          state_d = ST_PRIME;
        end
      end
      ST_EMIT: begin
        if (out_take && (a_q + cnt_t'(1) == count_q)) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    width_d     = width_q;
    a_d         = a_q;
    b_d         = b_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    k_d         = k_q;
    src_sel_d   = src_sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we0         = 1'b0;
    we1         = 1'b0;
    waddr       = k_q[ADDR_W-1:0];
    wdata       = take_left ? rec_a : rec_b;
    case (state_q)
      ST_LOAD: begin
        src_sel_d  = 1'b0;
        width_d    = cnt_t'(1);
        waddr      = count_q[ADDR_W-1:0];
        wdata      = '{key: in_item_i.sort_key, payload: in_item_i.payload};
        if (in_acc) begin
          we0     = 1'b1;
          count_d = count_q + cnt_t'(1);
        end
      end
      ST_PRIME: begin
        a_d   = '0;
        k_d   = '0;
        mid_d = run_mid;
        hi_d  = run_hi;
        b_d   = run_mid;
      end
      ST_MERGE: begin
        we0 = src_sel_q;
        we1 = !src_sel_q;
        k_d = k_q + cnt_t'(1);
        if (k_q + cnt_t'(1) == hi_q) begin
          if (hi_q == count_q) begin
            width_d   = width_x2[CNT_W-1:0];
            src_sel_d = !src_sel_q;
          end else begin
            a_d   = hi_q;
            mid_d = run_mid;
            hi_d  = run_hi;
            b_d   = run_mid;
          end
        end else if (take_left) begin
          a_d = a_q + cnt_t'(1);
        end else begin
          b_d = b_q + cnt_t'(1);
        end
      end
      ST_EMIT: begin
        if (out_take) begin
          out_valid_d          = 1'b1;
          out_d.sorted_key     = rec_a.key;
          out_d.sorted_payload = rec_a.payload;
          out_d.final_result   = (a_q + cnt_t'(1) == count_q);
          a_d                  = a_q + cnt_t'(1);
          if (a_q + cnt_t'(1) == count_q) begin
            count_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      width_q     <= cnt_t'(1);
      a_q         <= '0;
      b_q         <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      src_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      width_q     <= width_d;
      a_q         <= a_d;
      b_q         <= b_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      k_q         <= k_d;
      src_sel_q   <= src_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  srms_ram u_ram0 (
    .clk_i     (clk_i),
    .we_i      (we0),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (a_d[ADDR_W-1:0]),
    .raddr_b_i (b_d[ADDR_W-1:0]),
    .rdata_a_o (rd_a0),
    .rdata_b_o (rd_b0)
  );

  srms_ram u_ram1 (
    .clk_i     (clk_i),
    .we_i      (we1),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (a_d[ADDR_W-1:0]),
    .raddr_b_i (b_d[ADDR_W-1:0]),
    .rdata_a_o (rd_a1),
    .rdata_b_o (rd_b1)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
